FILE: rtl/debounced_pulse_rate_meter_unit_defines.svh
// Assertion macros shared by the rate meter RTL.
`ifndef DEBOUNCED_PULSE_RATE_METER_UNIT_DEFINES_SVH
`define DEBOUNCED_PULSE_RATE_METER_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define DPRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DPRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dprm_pkg.sv
`default_nettype none
package dprm_pkg;

  localparam int WINDOW_SECONDS     = 60;
  localparam int POS_W              = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
  localparam int FILLED_W           = $clog2(WINDOW_SECONDS + 1);
  localparam int TIME_W             = 32;
  localparam int DEBOUNCE_W         = 16;
  localparam int TALLY_W            = 16;
  localparam int TOTAL_W            = $clog2(WINDOW_SECONDS * (2**TALLY_W - 1) + 1);
  localparam int MINUTE_W           = 22;
  localparam int SECS_OUT_W         = 6;
  localparam int SPM_W              = 6;
  localparam int PROD_W             = (TOTAL_W + SPM_W > MINUTE_W) ? TOTAL_W + SPM_W
                                                                  : MINUTE_W + 1;
  localparam int CNT_W              = $clog2(PROD_W);

  localparam logic [SPM_W-1:0]      SECONDS_PER_MINUTE = SPM_W'(60);
  localparam logic [TALLY_W-1:0]    TALLY_MAX          = '1;
  localparam logic [MINUTE_W-1:0]   MINUTE_RATE_MAX    = '1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET     = DEBOUNCE_W'(100);

  localparam logic ACTION_PULSE = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] time_us;
  } dprm_in_t;

  typedef struct packed {
    logic                  pulse_accepted;
    logic [TALLY_W-1:0]    counts_per_second;
    logic [MINUTE_W-1:0]   counts_per_minute;
    logic [SECS_OUT_W-1:0] seconds_filled;
  } dprm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } dprm_state_t;

endpackage
`default_nettype wire

FILE: rtl/dprm_ram.sv
`default_nettype none
module dprm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 60
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/debounced_pulse_rate_meter_unit.sv
`default_nettype none
// Debounced pulse rate meter. Each request is either a detector pulse with its
// microsecond timestamp or a one-second tick, and each yields exactly one
// result. A pulse goes from idle straight to the emit state, which loads the
// output register once the output is free. A tick passes through the update
// state for the ring read-modify-write of the running window total, the
// multiply by 60, a bit-serial divide by the number of seconds held, one
// quotient bit per cycle, and the emit state. One request is worked on at a
// time; the next is accepted in the cycle after the previous result has moved
// into the output register, even if that result has not yet been taken. While
// a result waits in the output register and another is ready, the block holds
// and stalls its input. The per-second ring lives in a 60-entry synchronous RAM
// and needs no clearing.
module debounced_pulse_rate_meter_unit
  import dprm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire dprm_in_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output dprm_out_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [DEBOUNCE_W-1:0] cfg_wdata
);

`include "debounced_pulse_rate_meter_unit_defines.svh"

  dprm_state_t           state, state_next;
  logic [DEBOUNCE_W-1:0] debounce_time_us;
  logic [TIME_W-1:0]     last_counted_time;
  logic [TALLY_W-1:0]    pulse_tally;
  logic [POS_W-1:0]      ring_position;
  logic                  ring_full;
  logic [TOTAL_W-1:0]    window_total;
  logic [TALLY_W-1:0]    latest_rate;
  logic [MINUTE_W-1:0]   latest_minute_rate;
  logic                  res_accepted;

  logic [PROD_W-1:0]     div_q;
  logic [FILLED_W-1:0]   div_rem;
  logic [FILLED_W-1:0]   div_divisor;
  logic [CNT_W-1:0]      div_cnt;

  logic                  accept;
  logic                  pulse_taken;
  logic                  out_free;
  logic [FILLED_W-1:0]   filled;
  logic [TIME_W-1:0]     elapsed;
  logic                  pulse_ok;
  logic [FILLED_W:0]     rem_sh;
  logic                  q_bit;
  logic [PROD_W-1:0]     q_next;
  logic                  div_last;
  logic [TALLY_W-1:0]    ram_rdata;
  logic [TOTAL_W-1:0]    old_entry;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign pulse_taken = accept && (in_item.action == ACTION_PULSE);
  assign out_free    = !out_valid || !out_stall;
  assign filled   = ring_full ? FILLED_W'(WINDOW_SECONDS) : FILLED_W'(ring_position);
  assign elapsed  = in_item.time_us - last_counted_time;
  assign pulse_ok = (elapsed >= TIME_W'(debounce_time_us));

  // One restoring division step per cycle.
  assign rem_sh    = {div_rem, div_q[PROD_W-1]};
  assign q_bit     = (rem_sh >= {1'b0, div_divisor});
  assign q_next    = {div_q[PROD_W-2:0], q_bit};
  assign div_last  = (div_cnt == CNT_W'(PROD_W - 1));
  assign old_entry = ring_full ? TOTAL_W'(ram_rdata) : '0;

  dprm_ram #(
    .WIDTH (TALLY_W),
    .DEPTH (WINDOW_SECONDS)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (ring_position),
    .wdata (pulse_tally),
    .raddr (ring_position),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_item.action == ACTION_TICK) ? ST_UPDATE : ST_EMIT;
        end
      end
      ST_UPDATE: state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time_us   <= DEBOUNCE_RESET;
      last_counted_time  <= '0;
      pulse_tally        <= '0;
      ring_position      <= '0;
      ring_full          <= 1'b0;
      window_total       <= '0;
      latest_rate        <= '0;
      latest_minute_rate <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        debounce_time_us <= cfg_wdata;
      end
      // In the emit state a taken result is replaced directly below.
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_accepted <= (in_item.action == ACTION_PULSE) && pulse_ok;
            if (in_item.action == ACTION_PULSE && pulse_ok) begin
              last_counted_time <= in_item.time_us;
              if (pulse_tally != TALLY_MAX) begin
                pulse_tally <= pulse_tally + TALLY_W'(1);
              end
            end
          end
        end
        ST_UPDATE: begin
          // The entry being replaced leaves the window only once the ring has wrapped.
          window_total <= window_total - old_entry + TOTAL_W'(pulse_tally);
          latest_rate  <= pulse_tally;
          pulse_tally  <= '0;
          if (ring_position == POS_W'(WINDOW_SECONDS - 1)) begin
            ring_position <= '0;
            ring_full     <= 1'b1;
          end else begin
            ring_position <= ring_position + POS_W'(1);
          end
        end
        ST_MUL: begin
          div_q       <= PROD_W'(window_total) * PROD_W'(SECONDS_PER_MINUTE);
          div_divisor <= filled;
          div_rem     <= '0;
          div_cnt     <= '0;
        end
        ST_DIV: begin
          div_q   <= q_next;
          div_rem <= q_bit ? FILLED_W'(rem_sh - {1'b0, div_divisor}) : rem_sh[FILLED_W-1:0];
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_last) begin
            if (div_divisor == '0) begin
              latest_minute_rate <= '0;
            end else if (|q_next[PROD_W-1:MINUTE_W]) begin
              latest_minute_rate <= MINUTE_RATE_MAX;
            end else begin
              latest_minute_rate <= q_next[MINUTE_W-1:0];
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid                  <= 1'b1;
            out_item.pulse_accepted    <= res_accepted;
            out_item.counts_per_second <= latest_rate;
            out_item.counts_per_minute <= latest_minute_rate;
            out_item.seconds_filled    <= SECS_OUT_W'(filled);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `DPRM_ASSERT_ALWAYS(a_reset_clears_out, (rst |=> !out_valid), "result valid after reset")
  `DPRM_ASSERT(a_pos_in_range, (ring_position < POS_W'(WINDOW_SECONDS)), "ring position beyond window")
  `DPRM_ASSERT(a_out_from_emit, ($rose(out_valid) |-> $past(state) == ST_EMIT), "stray result")
  `DPRM_ASSERT(a_tally_monotonic, (pulse_taken |=> pulse_tally >= $past(pulse_tally)), "tally dropped")

endmodule
`default_nettype wire
